### rtl/core/vpp_pkg.sv
// Shared types and constants for the vertex perspective projection core.
`default_nettype none
package vpp_pkg;

  localparam int unsigned VertexBits = 16;
  localparam int unsigned CoefBits   = 32;
  localparam int unsigned HomBits    = CoefBits + VertexBits + 2;
  localparam int unsigned PixBits    = 12;
  localparam int unsigned LimBits    = 13;
  localparam int unsigned OutHomBits = 64;
  localparam int unsigned NumMatRegs = 6;
  localparam int unsigned AddrBits   = 6;
  localparam int unsigned DataBits   = 64;

  localparam logic [LimBits-1:0] ResetWidth  = 13'd400;
  localparam logic [LimBits-1:0] ResetHeight = 13'd300;
  localparam logic [LimBits-1:0] MaxLimit    = 13'd4096;

  typedef enum logic [2:0] {
    RegRow0Cols01 = 3'd0,
    RegRow0Cols23 = 3'd1,
    RegRow1Cols01 = 3'd2,
    RegRow1Cols23 = 3'd3,
    RegRow2Cols01 = 3'd4,
    RegRow2Cols23 = 3'd5,
    RegImageWidth = 3'd6,
    RegImageHeight = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [VertexBits-1:0] vertex_x;
    logic signed [VertexBits-1:0] vertex_y;
    logic signed [VertexBits-1:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic [PixBits-1:0]           pixel_x;
    logic [PixBits-1:0]           pixel_y;
    logic signed [OutHomBits-1:0] hom_x;
    logic signed [OutHomBits-1:0] hom_y;
    logic signed [OutHomBits-1:0] hom_depth;
    logic                         depth_zero;
  } pixel_t;

endpackage
`default_nettype wire

### rtl/core/vertex_perspective_projection_core.sv
// Top level: pipelined 3x4 projection, divide by depth, round and clamp.
//
//  channel  | direction | handshake                        | payload
//  ---------+-----------+----------------------------------+------------------
//  vertex   | in        | in_valid_i / in_stall_o          | in_data_i (vertex_t)
//  pixel    | out       | out_valid_o / out_stall_i        | out_data_o (pixel_t)
//  config   | in        | psel/penable/pwrite/pready (APB) | paddr, pwdata, prdata
//
// One vertex per cycle while the output is not stalled; stages: multiply, sum, abs, 12 quotient
// stages (one restoring step each), round/clamp into the output register.
// Reset clears valid bits and loads register defaults (matrix 0, 400 x 300).
// A stalled output holds the whole pipeline; bubbles move when it is free.
`default_nettype none
module vertex_perspective_projection_core
  import vpp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire vertex_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output pixel_t                   out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0]      prdata,
  output logic                     pready
);

  localparam int unsigned ProdBits = CoefBits + VertexBits;
  localparam int unsigned QBits    = PixBits;
  localparam int unsigned XBits    = HomBits + QBits;

  // ---------------- configuration ----------------
  logic [DataBits-1:0] mat_q [NumMatRegs];
  logic [LimBits-1:0]  width_q, height_q;
  reg_idx_e            widx;
  logic                wr_en;

  assign pready = 1'b1;
  assign widx   = reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumMatRegs; i++) mat_q[i] <= '0;
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
    end else if (wr_en) begin
      unique case (widx)
        RegImageWidth:  width_q  <= pwdata[LimBits-1:0];
        RegImageHeight: height_q <= pwdata[LimBits-1:0];
        default:        mat_q[widx] <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      RegImageWidth:  prdata = {{(DataBits-LimBits){1'b0}}, width_q};
      RegImageHeight: prdata = {{(DataBits-LimBits){1'b0}}, height_q};
      default:        prdata = mat_q[widx];
    endcase
  end

  function automatic logic [PixBits-1:0] eff_lim(input logic [LimBits-1:0] v);
    logic [LimBits-1:0] t;
    begin
      t = v;
      if (t == '0) t = LimBits'(1);
      if (t > MaxLimit) t = MaxLimit;
      eff_lim = PixBits'(t - LimBits'(1));
    end
  endfunction

  logic [PixBits-1:0] lim [2];
  assign lim[0] = eff_lim(width_q);
  assign lim[1] = eff_lim(height_q);

  // ---------------- flow control ----------------
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // ---------------- stage A: products ----------------
  logic                       a_valid_q;
  logic signed [ProdBits-1:0] prod_q [3][3];
  logic signed [CoefBits-1:0] offs_q [3];
  logic signed [ProdBits-1:0] prod_d [3][3];
  logic signed [VertexBits-1:0] vin [3];

  assign vin[0] = in_data_i.vertex_x;
  assign vin[1] = in_data_i.vertex_y;
  assign vin[2] = in_data_i.vertex_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(mat_q[2*r + c/2][32*(c%2) +: CoefBits]) * vin[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_valid_q <= 1'b0;
    else if (adv) a_valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
      for (int r = 0; r < 3; r++) offs_q[r] <= $signed(mat_q[2*r+1][63:32]);
    end
  end

  // ---------------- stage B: sums ----------------
  logic                      b_valid_q;
  logic signed [HomBits-1:0] hom_b_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_valid_q <= 1'b0;
    else if (adv) b_valid_q <= a_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        hom_b_q[r] <= HomBits'(prod_q[r][0]) + HomBits'(prod_q[r][1])
                    + HomBits'(prod_q[r][2]) + HomBits'(offs_q[r]);
      end
    end
  end

  // ---------------- stage C and quotient stages ----------------
  // Index 0 is the output of stage C; quotient stage j writes index j+1.
  logic                      v_q    [QBits+1];
  logic signed [HomBits-1:0] hom_q  [QBits+1][3];
  logic                      zero_q [QBits+1];
  logic [HomBits-1:0]        den_q  [QBits+1];
  logic [HomBits-1:0]        rem_q  [QBits+1][2];
  logic [QBits-1:0]          quo_q  [QBits+1][2];
  logic                      neg_q  [QBits+1][2];
  logic                      sat_q  [QBits+1][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (adv) v_q[0] <= b_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hom_q[0]  <= hom_b_q;
      zero_q[0] <= (hom_b_q[2] == '0);
      den_q[0]  <= hom_b_q[2][HomBits-1] ? HomBits'(-hom_b_q[2]) : HomBits'(hom_b_q[2]);
      for (int a = 0; a < 2; a++) begin
        rem_q[0][a] <= hom_b_q[a][HomBits-1] ? HomBits'(-hom_b_q[a]) : HomBits'(hom_b_q[a]);
        quo_q[0][a] <= '0;
        // quotient sign is negative when signs differ and numerator is nonzero
        neg_q[0][a] <= (hom_b_q[a] != '0) && (hom_b_q[a][HomBits-1] ^ hom_b_q[2][HomBits-1]);
        sat_q[0][a] <= 1'b0;
      end
    end
  end

  for (genvar j = 0; j < QBits; j++) begin : g_div
    localparam int unsigned K = QBits - 1 - j;
    logic [XBits-1:0]   shd;
    logic [XBits-1:0]   rx [2];
    logic               ge [2];
    logic [HomBits-1:0] rem_d [2];
    logic               sat_d [2];

    assign shd = {{QBits{1'b0}}, den_q[j]} << K;

    always_comb begin
      for (int a = 0; a < 2; a++) begin
        rx[a]    = {{QBits{1'b0}}, rem_q[j][a]};
        ge[a]    = rx[a] >= shd;
        rem_d[a] = ge[a] ? HomBits'(rx[a] - shd) : rem_q[j][a];
        if (j == 0) sat_d[a] = rx[a] >= {den_q[j], {QBits{1'b0}}};
        else        sat_d[a] = sat_q[j][a];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[j+1] <= 1'b0;
      else if (adv) v_q[j+1] <= v_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        hom_q[j+1]  <= hom_q[j];
        zero_q[j+1] <= zero_q[j];
        den_q[j+1]  <= den_q[j];
        for (int a = 0; a < 2; a++) begin
          rem_q[j+1][a] <= rem_d[a];
          quo_q[j+1][a] <= quo_q[j][a] | (QBits'(ge[a]) << K);
          neg_q[j+1][a] <= neg_q[j][a];
          sat_q[j+1][a] <= sat_d[a];
        end
      end
    end
  end

  // ---------------- round, clamp, output register ----------------
  logic [PixBits-1:0] pix_d [2];

  always_comb begin
    logic [HomBits:0]   r2;
    logic [HomBits:0]   dd;
    logic               up;
    logic [QBits:0]     qr;
    for (int a = 0; a < 2; a++) begin
      r2 = {rem_q[QBits][a], 1'b0};
      dd = {1'b0, den_q[QBits]};
      // half to even
      up = (r2 > dd) || ((r2 == dd) && quo_q[QBits][a][0]);
      qr = {1'b0, quo_q[QBits][a]} + (QBits+1)'(up);
      priority if (zero_q[QBits] || neg_q[QBits][a]) pix_d[a] = '0;
      else if (sat_q[QBits][a])                        pix_d[a] = lim[a];
      else if (qr > {1'b0, lim[a]})                    pix_d[a] = lim[a];
      else                                             pix_d[a] = qr[PixBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= v_q[QBits];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o.pixel_x    <= pix_d[0];
      out_data_o.pixel_y    <= pix_d[1];
      out_data_o.hom_x      <= OutHomBits'(hom_q[QBits][0]);
      out_data_o.hom_y      <= OutHomBits'(hom_q[QBits][1]);
      out_data_o.hom_depth  <= OutHomBits'(hom_q[QBits][2]);
      out_data_o.depth_zero <= zero_q[QBits];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### rtl/core/vpp_checker.sv
// Port-level checker for the projection core, bound to the top level.
`default_nettype none
module vpp_checker
  import vpp_pkg::*;
(
  input wire logic   clk_i,
  input wire logic   rst_ni,
  input wire logic   in_stall_o,
  input wire logic   out_valid_o,
  input wire logic   out_stall_i,
  input wire pixel_t out_data_o
);

  a_zero_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.depth_zero |->
      (out_data_o.pixel_x == '0) && (out_data_o.pixel_y == '0))
    else $error("zero depth with nonzero pixel");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.depth_zero == (out_data_o.hom_depth == '0)))
    else $error("depth flag disagrees with depth");

  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output blocked");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

endmodule

bind vertex_perspective_projection_core vpp_checker u_vpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
